FILE: hdl/skvt_pkg.sv
package skvt_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic [COUNT_W-1:0]    entry_count;
  } rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                  cmp;
    logic [KEY_BITS-1:0]   cmp_key;
    logic                  ins;
    logic                  upd;
    logic                  clr;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_cmd_t;

  // What a cell shows to its right neighbor and to the controller.
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic                  valid;
    logic                  lt;
    logic                  eq;
  } cell_state_t;

endpackage

FILE: hdl/skvt_cell.sv
module skvt_cell import skvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_cmd_t   cmd,
  input  cell_state_t left,
  output cell_state_t self
);

  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  valid;
  logic                  lt;
  logic                  eq;

  // Control: compare flags and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        lt <= valid && (key < cmd.cmp_key);
        eq <= valid && (key == cmd.cmp_key);
      end
      if (cmd.clr) begin
        valid <= 1'b0;
      end else if (cmd.ins && !lt) begin
        valid <= left.valid;
      end
    end
  end

  // Payload: insert at gap, shift from the left above, update on a match.
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      if (left.lt) begin
        key   <= cmd.key;
        value <= cmd.value;
      end else begin
        key   <= left.key;
        value <= left.value;
      end
    end else if (cmd.upd && eq) begin
      value <= cmd.value;
    end
  end

  assign self = '{key: key, value: value, valid: valid, lt: lt, eq: eq};

endmodule

FILE: hdl/sorted_key_value_table_unit.sv
// Sorted key-value table built as a row of compare-and-shift cells.
// Flow: the cells compare at the accepting edge, then insert, update or clear in the
//   execute step, which also registers the response.
// Handshake: one transaction at a time; a new request is taken only once the execute step
//   ends, and a response left waiting holds the execute step, and with it the request side.
// Reset: synchronous, active high; empties the table and drops any pending response.
module sorted_key_value_table_unit import skvt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state;
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [COUNT_W-1:0]    count;

  cell_cmd_t   cmd;
  cell_state_t cells [CAPACITY];
  cell_state_t head;

  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  full;
  logic                  rsp_free;
  logic                  do_exec;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign do_exec   = (state == S_EXEC) && rsp_free;
  assign full      = (count == COUNT_W'(CAPACITY));

  // Left edge of the row: always occupied and "less than", so cell 0 takes the
  // new pair whenever it is at or above the insertion point.
  assign head = '{key: '0, value: '0, valid: 1'b1, lt: 1'b1, eq: 1'b0};

  // Reduce the per-cell match flags. Keys are unique, so at most one cell hits.
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | cells[i].eq;
      hit_value = hit_value | (cells[i].eq ? cells[i].value : '0);
    end
  end

  // Broadcast: compare on acceptance against the incoming key, act in the execute step.
  always_comb begin
    cmd.cmp     = req_valid && req_ready;
    cmd.cmp_key = req.key;
    cmd.key     = key;
    cmd.value   = value;
    cmd.ins     = do_exec && (op == OP_INSERT) && !hit && !full;
    cmd.upd     = do_exec && (op == OP_INSERT) && hit;
    cmd.clr     = do_exec && (op == OP_CLEAR);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .left ((i == 0) ? head : cells[(i == 0) ? 0 : i - 1]),
      .self (cells[i])
    );
  end

  // Control and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise on a new response, hold while the receiver stalls, drop once taken.
      rsp_valid <= do_exec || (rsp_valid && !rsp_ready);
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Hold until the response register is free.
          if (rsp_free) begin
            state <= S_IDLE;
            if (op == OP_CLEAR) begin
              count <= '0;
            end else if (op == OP_INSERT && !hit && !full) begin
              count <= count + COUNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request latch and response payload.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op    <= req.operation;
      key   <= req.key;
      value <= req.value;
    end
    if (do_exec) begin
      case (op)
        OP_INSERT: begin
          rsp.found_value <= '0;
          if (hit) begin
            rsp.status      <= ST_UPDATED;
            rsp.entry_count <= count;
          end else if (full) begin
            rsp.status      <= ST_FULL;
            rsp.entry_count <= count;
          end else begin
            rsp.status      <= ST_INSERTED;
            rsp.entry_count <= count + COUNT_W'(1);
          end
        end
        OP_LOOKUP: begin
          rsp.status      <= hit ? ST_HIT : ST_MISS;
          rsp.found_value <= hit ? hit_value : '0;
          rsp.entry_count <= count;
        end
        OP_CLEAR: begin
          rsp.status      <= ST_CLEARED;
          rsp.found_value <= '0;
          rsp.entry_count <= '0;
        end
        default: begin
          rsp.status      <= ST_MISS;
          rsp.found_value <= '0;
          rsp.entry_count <= count;
        end
      endcase
    end
  end

endmodule

FILE: hdl/skvt_checker.sv
module skvt_checker import skvt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_CLEARED)
    else $error("status code out of range");

  a_found_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_HIT |-> rsp.found_value == '0)
    else $error("found value set without a hit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_CLEARED |-> rsp.entry_count == '0)
    else $error("clear left entries");

endmodule

bind sorted_key_value_table_unit skvt_checker u_skvt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
